// ===== rtl/core/frwm_pkg.sv =====
// Shared constants and types for the frame rate window meter.
package frwm_pkg;

	// Window geometry
	localparam int WINDOW_DEPTH = 64;
	localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

	// Field widths
	localparam int TIME_W = 32;
	localparam int RATE_W = 16;
	localparam int SUM_W  = TIME_W + SLOT_W;

	// Rate arithmetic
	localparam int MS_PER_SECOND = 1000;
	localparam int RATE_MAX      = 65535;
	localparam int NUM_W         = $clog2(MS_PER_SECOND * WINDOW_DEPTH + 1);
	localparam int CNT_W         = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	// Event kinds carried on the input tuser
	localparam logic CMD_START = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/frame_rate_window_meter.sv =====
// Moving-average frame rate meter over a ring of millisecond intervals.

// Each input beat is a start event or a frame mark with a millisecond timestamp and
// yields exactly one output beat. A start empties the window and returns rate 0. A
// frame mark stores the interval since the previous event in a 64-entry ring memory,
// updates the running sum and returns floor(1000 * filled / sum), saturated to 65535
// with the flag set when the sum is zero or the quotient is too large. One beat at a
// time is processed: a start goes straight to the hand-off, while a frame mark passes
// through the ring read, the sum update, the restoring divider that produces one
// quotient bit per cycle, and the hand-off of the result to the output register. A finished
// result waits in the output register, so the next input beat is taken while it waits;
// the hand-off stretches for as long as an earlier beat is still held there.
module frame_rate_window_meter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [frwm_pkg::TIME_W-1:0] s_tdata,   // [31:0] time_ms
	input  logic                        s_tuser,   // [0] cmd
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [frwm_pkg::RATE_W-1:0] m_tdata,   // [15:0] rate
	output logic                        m_tuser    // [0] saturated
);
	import frwm_pkg::*;

	// Ring memory
	logic [TIME_W-1:0] ring [WINDOW_DEPTH];
	logic [TIME_W-1:0] rd_data_q;

	// Window state
	logic [SUM_W-1:0]  sum_q;
	logic [SLOT_W-1:0] slot_q;
	logic [FILL_W-1:0] fill_q;
	logic [TIME_W-1:0] last_time_q;
	logic [TIME_W-1:0] interval_q;
	logic              start_q;

	// Divider
	logic [NUM_W-1:0]  num_q;
	logic [SUM_W-1:0]  rem_q;
	logic [CNT_W-1:0]  cnt_q;

	// Output register
	logic              m_tvalid_q;
	logic [RATE_W-1:0] m_tdata_q;
	logic              m_tuser_q;

	// Sequencer
	state_t state_q, state_d;
	logic   accept;
	logic   out_free;
	logic   rd_en;
	logic   wr_en;
	logic   load_out;

	logic              full;
	logic [FILL_W-1:0] fill_next;
	logic [SUM_W-1:0]  sum_next;
	logic [SUM_W:0]    rem_shift;
	logic [SUM_W:0]    rem_trial;
	logic              over;
	logic [RATE_W-1:0] res_rate;
	logic              res_sat;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign full     = (fill_q == FILL_W'(WINDOW_DEPTH));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser == CMD_START) ? ST_DONE : ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == '0) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				rd_en    = s_tvalid && (s_tuser == CMD_FRAME);
			end
			ST_UPDATE: wr_en = 1'b1;
			ST_DIV:    ;
			ST_DONE:   load_out = out_free;
			default:   ;
		endcase
	end

	// Window update: drop the oldest interval once full, add the new one
	always_comb begin
		fill_next = full ? fill_q : fill_q + FILL_W'(1);
		sum_next  = sum_q - (full ? SUM_W'(rd_data_q) : '0) + SUM_W'(interval_q);
	end

	// One restoring division step
	always_comb begin
		rem_shift = {rem_q, num_q[NUM_W-1]};
		rem_trial = rem_shift - {1'b0, sum_q};
	end

	// Saturate the quotient
	always_comb begin
		over = ((num_q >> RATE_W) != '0);
		if (start_q) begin
			res_rate = '0;
			res_sat  = 1'b0;
		end else if (sum_q == '0 || over) begin
			res_rate = RATE_W'(RATE_MAX);
			res_sat  = 1'b1;
		end else begin
			res_rate = RATE_W'(num_q);
			res_sat  = 1'b0;
		end
	end

	// Ring memory: registered read, single write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= ring[slot_q];
		end
		if (wr_en) begin
			ring[slot_q] <= interval_q;
		end
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Window state: clear on start, advance on frame mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			slot_q      <= '0;
			fill_q      <= '0;
			last_time_q <= '0;
			start_q     <= 1'b0;
		end else if (accept) begin
			last_time_q <= s_tdata;
			start_q     <= (s_tuser == CMD_START);
			if (s_tuser == CMD_START) begin
				sum_q  <= '0;
				slot_q <= '0;
				fill_q <= '0;
			end
		end else if (state_q == ST_UPDATE) begin
			sum_q  <= sum_next;
			fill_q <= fill_next;
			slot_q <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
		end
	end

	// Interval capture and divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			interval_q <= s_tdata - last_time_q;
		end
		if (state_q == ST_UPDATE) begin
			num_q <= NUM_W'(fill_next * MS_PER_SECOND);
			rem_q <= '0;
			cnt_q <= CNT_W'(NUM_W - 1);
		end else if (state_q == ST_DIV) begin
			if (!rem_trial[SUM_W]) begin
				rem_q <= rem_trial[SUM_W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift[SUM_W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Output register: hold a beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= res_rate;
			m_tuser_q <= res_sat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
